/* src/srt_pkg.sv */
// Shared types, opcodes and constants of the stamped recency table.
package srt_pkg;

   localparam int CAPACITY_DEF = 8;

   localparam logic [7:0] STAMP_LIMIT = 8'd255;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_NEXT   = 2'd2;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_MISS = 1'b1;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key;
      logic [63:0] value;
      logic [7:0]  stamp_query;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [63:0] found_key;
      logic [63:0] found_value;
      logic [7:0]  found_stamp;
      logic [7:0]  last_used;
   } rsp_type;

endpackage

/* src/srt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module srt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/stamped_recency_table.sv */
// Stamped recency table: keyed store of up to CAPACITY entries with 8-bit recency stamps.
//
// Takes one request at a time and answers each with exactly one response.
// Insert updates the value of a matching key, else appends, else (full)
// overwrites the entry with the lowest stamp; the touched entry gets stamp
// max+1 (0 in an empty table), which also becomes last_used. Lookup finds
// the entry holding a stamp; next finds the smallest stamp above the query,
// wrapping to the lowest. Requests that scan walk the stored entries through
// one read port per store and one compare datapath, one entry per cycle;
// op 3 and requests on an empty table skip the walk. When the highest stamp
// has reached 255 an insert first renumbers the stamps to their ranks, with
// one pivot read plus N compare reads per entry, for N entries held. The
// ranks go to a second stamp bank that then becomes the active one. A new
// request is taken while an earlier response still waits; the block stalls
// only when its next response is ready and the old one is still unclaimed.
module stamped_recency_table
   import srt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // entry index
   localparam int CW = $clog2(CAPACITY + 1);                   // entry count
   localparam int XW = CW + 1;                                 // read issue counter

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RANK,
      ST_WRITE,
      ST_FETCH,
      ST_FETCH_DATA,
      ST_MISS
   } state_type;

   state_type state_ff, state_in;

   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    last_use_ff, last_use_in;
   logic          bank_ff, bank_in;          // which stamp RAM is live

   // read sequencing
   logic [XW-1:0] issue_ff, issue_in;
   logic          p_vld_ff, p_vld_in;        // read data arriving this cycle
   logic          p_pivot_ff, p_pivot_in;
   logic [IW-1:0] p_idx_ff, p_idx_in;

   // scan results
   logic          match_ff, match_in;
   logic [IW-1:0] match_idx_ff, match_idx_in;
   logic [7:0]    max_ff, max_in;
   logic [IW-1:0] min_idx_ff, min_idx_in;
   logic [7:0]    min_stamp_ff, min_stamp_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic          have_ff, have_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [7:0]    best_stamp_ff, best_stamp_in;
   logic [IW-1:0] fetch_idx_ff, fetch_idx_in;
   logic [7:0]    stamp_new_ff, stamp_new_in;

   // renumbering
   logic [IW-1:0] rank_i_ff, rank_i_in;
   logic [7:0]    pivot_ff, pivot_in;
   logic [7:0]    rank_cnt_ff, rank_cnt_in;

   // memory side
   logic [IW-1:0] rd_addr;
   logic [63:0]   key_rd, val_rd;
   logic [7:0]    stamp0_rd, stamp1_rd, stamp_rd;
   logic          wr_now;                    // entry write in WRITE
   logic          rank_we;                   // rank write to idle bank
   logic [IW-1:0] slot;
   logic          out_free;
   logic          issuing;
   logic [XW-1:0] j_sel;
   logic [CW-1:0] count_m1;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign stamp_rd = bank_ff ? stamp1_rd : stamp0_rd;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign j_sel    = issue_ff - XW'(1);
   assign count_m1 = count_ff - CW'(1);

   // target entry of an insert: matched key, else append, else evict lowest
   always_comb begin
      if (match_ff) begin
         slot = match_idx_ff;
      end else if (count_ff < CW'(CAPACITY)) begin
         slot = count_ff[IW-1:0];
      end else begin
         slot = min_idx_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      count_in      = count_ff;
      last_use_in   = last_use_ff;
      bank_in       = bank_ff;
      issue_in      = issue_ff;
      p_vld_in      = 1'b0;
      p_pivot_in    = 1'b0;
      p_idx_in      = p_idx_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      max_in        = max_ff;
      min_idx_in    = min_idx_ff;
      min_stamp_in  = min_stamp_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      have_in       = have_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      fetch_idx_in  = fetch_idx_ff;
      stamp_new_in  = stamp_new_ff;
      rank_i_in     = rank_i_ff;
      pivot_in      = pivot_ff;
      rank_cnt_in   = rank_cnt_ff;
      rd_addr       = '0;
      wr_now        = 1'b0;
      rank_we       = 1'b0;
      issuing       = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               match_in  = 1'b0;
               hit_in    = 1'b0;
               have_in   = 1'b0;
               max_in    = '0;
               issue_in  = '0;
               rank_i_in = '0;
               case (req_data.op) inside
                  OP_INSERT: begin
                     if (count_ff == '0) begin
                        stamp_new_in = '0;
                        state_in     = ST_WRITE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_LOOKUP, OP_NEXT: begin
                     state_in = (count_ff == '0) ? ST_MISS : ST_SCAN;
                  end
                  default: begin
                     state_in = ST_MISS;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            issuing = (issue_ff < XW'(count_ff));
            if (issuing) begin
               rd_addr  = issue_ff[IW-1:0];
               p_vld_in = 1'b1;
               p_idx_in = issue_ff[IW-1:0];
               issue_in = issue_ff + XW'(1);
            end
            if (p_vld_ff) begin
               if (req_ff.op == OP_INSERT && key_rd == req_ff.key && !match_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = p_idx_ff;
               end
               if (stamp_rd > max_ff) begin
                  max_in = stamp_rd;
               end
               if (p_idx_ff == '0 || stamp_rd < min_stamp_ff) begin
                  min_idx_in   = p_idx_ff;
                  min_stamp_in = stamp_rd;
               end
               if (stamp_rd == req_ff.stamp_query && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = p_idx_ff;
               end
               if (stamp_rd > req_ff.stamp_query &&
                   (!have_ff || stamp_rd < best_stamp_ff)) begin
                  have_in       = 1'b1;
                  best_idx_in   = p_idx_ff;
                  best_stamp_in = stamp_rd;
               end
            end
            if (!issuing && !p_vld_ff) begin
               case (req_ff.op)
                  OP_INSERT: begin
                     if (max_ff == STAMP_LIMIT) begin
                        issue_in  = '0;
                        rank_i_in = '0;
                        state_in  = ST_RANK;
                     end else begin
                        stamp_new_in = max_ff + 8'd1;
                        state_in     = ST_WRITE;
                     end
                  end
                  OP_LOOKUP: begin
                     fetch_idx_in = hit_idx_ff;
                     state_in     = hit_ff ? ST_FETCH : ST_MISS;
                  end
                  OP_NEXT: begin
                     fetch_idx_in = have_ff ? best_idx_ff : min_idx_ff;
                     state_in     = ST_FETCH;
                  end
                  default: begin
                     state_in = ST_MISS;
                  end
               endcase
            end
         end

         // per entry: read its stamp as pivot, then count stamps ranked below
         ST_RANK: begin
            issuing = (issue_ff <= XW'(count_ff));
            if (issuing) begin
               rd_addr    = (issue_ff == '0) ? rank_i_ff : j_sel[IW-1:0];
               p_vld_in   = 1'b1;
               p_pivot_in = (issue_ff == '0);
               p_idx_in   = rd_addr;
               issue_in   = issue_ff + XW'(1);
            end
            if (p_vld_ff) begin
               if (p_pivot_ff) begin
                  pivot_in    = stamp_rd;
                  rank_cnt_in = '0;
               end else if (stamp_rd < pivot_ff ||
                            (stamp_rd == pivot_ff && p_idx_ff < rank_i_ff)) begin
                  rank_cnt_in = rank_cnt_ff + 8'd1;
               end
            end
            if (!issuing && !p_vld_ff) begin
               rank_we = 1'b1;
               if (CW'(rank_i_ff) == count_m1) begin
                  bank_in      = !bank_ff;
                  stamp_new_in = 8'(count_ff);   // highest rank is count-1
                  state_in     = ST_WRITE;
               end else begin
                  rank_i_in = rank_i_ff + IW'(1);
                  issue_in  = '0;
               end
            end
         end

         ST_WRITE: begin
            if (out_free) begin
               wr_now              = 1'b1;
               rsp_valid_in        = 1'b1;
               rsp_in.status       = STATUS_OK;
               rsp_in.found_key    = req_ff.key;
               rsp_in.found_value  = req_ff.value;
               rsp_in.found_stamp  = stamp_new_ff;
               rsp_in.last_used    = stamp_new_ff;
               last_use_in         = stamp_new_ff;
               if (!match_ff && count_ff < CW'(CAPACITY)) begin
                  count_in = count_ff + CW'(1);
               end
               state_in = ST_IDLE;
            end
         end

         ST_FETCH: begin
            rd_addr  = fetch_idx_ff;
            state_in = ST_FETCH_DATA;
         end

         ST_FETCH_DATA: begin
            rd_addr = fetch_idx_ff;      // hold read data while stalled
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = STATUS_OK;
               rsp_in.found_key    = key_rd;
               rsp_in.found_value  = val_rd;
               rsp_in.found_stamp  = stamp_rd;
               rsp_in.last_used    = last_use_ff;
               state_in            = ST_IDLE;
            end
         end

         ST_MISS: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.status       = STATUS_MISS;
               rsp_in.found_key    = '0;
               rsp_in.found_value  = '0;
               rsp_in.found_stamp  = '0;
               rsp_in.last_used    = last_use_ff;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         last_use_ff  <= '0;
         bank_ff      <= 1'b0;
         p_vld_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         last_use_ff  <= last_use_in;
         bank_ff      <= bank_in;
         p_vld_ff     <= p_vld_in;
      end
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      issue_ff      <= issue_in;
      p_pivot_ff    <= p_pivot_in;
      p_idx_ff      <= p_idx_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      max_ff        <= max_in;
      min_idx_ff    <= min_idx_in;
      min_stamp_ff  <= min_stamp_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      have_ff       <= have_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      fetch_idx_ff  <= fetch_idx_in;
      stamp_new_ff  <= stamp_new_in;
      rank_i_ff     <= rank_i_in;
      pivot_ff      <= pivot_in;
      rank_cnt_ff   <= rank_cnt_in;
   end

   // Stores. The live stamp bank takes entry writes; the idle one takes ranks.
   logic          s0_we, s1_we;
   logic [IW-1:0] s_wr_addr;
   logic [7:0]    s_wr_data;

   assign s0_we     = (wr_now && !bank_ff) || (rank_we && bank_ff);
   assign s1_we     = (wr_now && bank_ff) || (rank_we && !bank_ff);
   assign s_wr_addr = wr_now ? slot : rank_i_ff;
   assign s_wr_data = wr_now ? stamp_new_ff : rank_cnt_ff;

   srt_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_now),
      .wr_addr (slot),
      .wr_data (req_ff.key),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   srt_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (wr_now),
      .wr_addr (slot),
      .wr_data (req_ff.value),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   srt_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_stamp0_ram (
      .clock   (clock),
      .wr_en   (s0_we),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_addr (rd_addr),
      .rd_data (stamp0_rd)
   );

   srt_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_stamp1_ram (
      .clock   (clock),
      .wr_en   (s1_we),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_addr (rd_addr),
      .rd_data (stamp1_rd)
   );

endmodule
